@@ hw/rtl/i2cms_pkg.sv @@
// Shared types and constants for the I2C master bit sequencer.
// Used by the front end, the command queue, the sequencer and the top level.
package i2cms_pkg;

    // Command codes carried on the input tuser field.
    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_WRITE    = 3'd2,
        OP_READ     = 3'd3,
        OP_SEND_ACK = 3'd4,
        OP_RECV_ACK = 3'd5
    } t_opcode;

    // One classified command as it travels through the queue.
    typedef struct packed {
        t_opcode    op;
        logic [7:0] tx_byte;
        logic       ack_out;
        logic [7:0] bus_levels;
    } t_cmd;

    // Sequencer states.
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    localparam int          CMD_QUEUE_DEPTH = 2;
    localparam logic [15:0] HOLD_RESET      = 16'd720;
    localparam logic [2:0]  BIT_LAST        = 3'd7;
    localparam logic [1:0]  PHASE_LOW       = 2'd2;
    localparam logic [1:0]  PHASE_START_END = 2'd3;
    localparam logic [7:0]  MSB_MASK        = 8'h80;

endpackage

@@ hw/rtl/i2cms_front.sv @@
// Front end: accepts command words, drops unused opcodes and registers the rest.
// Depends on i2cms_pkg for the command struct and opcode codes.
module i2cms_front
    import i2cms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_ack_out,
    input  logic [7:0]  i_bus_levels,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    logic w_known;

    // Only the six defined opcodes produce any line activity.
    assign w_known = (i_opcode <= OP_RECV_ACK);
    assign o_ready = !r_valid || i_cmd_ready;

    // Single holding register in front of the queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && w_known;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid && w_known) begin
            r_cmd.op         <= t_opcode'(i_opcode);
            r_cmd.tx_byte    <= i_tx_byte;
            r_cmd.ack_out    <= i_ack_out;
            r_cmd.bus_levels <= i_bus_levels;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

@@ hw/rtl/i2cms_cmd_queue.sv @@
// Short command queue decoupling the front end from the line sequencer.
// Depends on i2cms_pkg for the command struct.
module i2cms_cmd_queue
    import i2cms_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_cmd i_push_cmd,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_cmd o_pop_cmd
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_cmd    = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hw/rtl/i2cms_back.sv @@
// Line sequencer: walks each command through its SCL/SDA steps and paces them.
// Depends on i2cms_pkg for the command struct, opcodes and state type.
module i2cms_back
    import i2cms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_hold_cycles,
    input  logic        i_cmd_valid,
    output logic        o_cmd_ready,
    input  t_cmd        i_cmd,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_is_sample,
    output logic [7:0]  o_rx_byte,
    output logic        o_ack_in,
    output logic        o_last
);

    t_seq_state  r_state, n_state;
    t_cmd        r_cmd;
    logic [1:0]  r_phase, n_phase;
    logic [2:0]  r_bit, n_bit;
    logic        r_lead, n_lead;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;
    logic [15:0] r_hold;

    logic        r_out_valid;
    logic        r_out_scl, r_out_sda, r_out_smp, r_out_ack, r_out_last;
    logic [7:0]  r_out_rx;

    logic        w_issue;
    logic        w_smp;
    logic        w_ack;
    logic        w_fin;
    logic [7:0]  w_rx;
    logic        w_load;

    // A step goes out once the hold time has run and the output slot is free.
    assign w_issue     = (r_state == SEQ_RUN) && (r_hold == '0) &&
                         (!r_out_valid || i_ready);
    assign o_cmd_ready = (r_state == SEQ_IDLE);
    assign w_load      = o_cmd_ready && i_cmd_valid;

    // Step decode: the line change and reported fields for the current step.
    always_comb begin
        n_scl = r_scl;
        n_sda = r_sda;
        w_smp = 1'b0;
        w_rx  = '0;
        w_ack = 1'b0;
        w_fin = 1'b0;
        unique case (r_cmd.op)
            OP_START: begin
                unique case (r_phase)
                    2'd0:    n_sda = 1'b1;
                    2'd1:    n_scl = 1'b1;
                    2'd2:    n_sda = 1'b0;
                    default: begin
                        n_scl = 1'b0;
                        w_fin = 1'b1;
                    end
                endcase
            end
            OP_STOP: begin
                unique case (r_phase)
                    2'd0:    n_sda = 1'b0;
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_sda = 1'b1;
                        w_fin = 1'b1;
                    end
                endcase
            end
            OP_WRITE: begin
                unique case (r_phase)
                    2'd0:    n_sda = |(r_cmd.tx_byte & (MSB_MASK >> r_bit));
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_scl = 1'b0;
                        w_fin = (r_bit == BIT_LAST);
                    end
                endcase
            end
            OP_SEND_ACK: begin
                unique case (r_phase)
                    2'd0:    n_sda = r_cmd.ack_out;
                    2'd1:    n_scl = 1'b1;
                    default: begin
                        n_scl = 1'b0;
                        w_fin = 1'b1;
                    end
                endcase
            end
            OP_READ, OP_RECV_ACK: begin
                if (r_lead) begin
                    n_sda = 1'b1;
                end else begin
                    unique case (r_phase)
                        2'd0:    n_scl = 1'b1;
                        2'd1:    w_smp = 1'b1;
                        default: begin
                            n_scl = 1'b0;
                            if (r_cmd.op == OP_READ) begin
                                // After eight samples the byte equals the levels seen.
                                w_fin = (r_bit == BIT_LAST);
                                w_rx  = w_fin ? r_cmd.bus_levels : 8'h00;
                            end else begin
                                w_fin = 1'b1;
                                w_ack = r_cmd.bus_levels[7];
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    // Step counters and state: next values.
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_lead  = r_lead;
        unique case (r_state)
            SEQ_IDLE: begin
                if (w_load) begin
                    n_state = SEQ_RUN;
                    n_phase = '0;
                    n_bit   = '0;
                    n_lead  = (i_cmd.op == OP_READ) || (i_cmd.op == OP_RECV_ACK);
                end
            end
            SEQ_RUN: begin
                if (w_issue) begin
                    if (w_fin) begin
                        n_state = SEQ_IDLE;
                    end else if (r_lead) begin
                        n_lead = 1'b0;
                    end else if (r_cmd.op == OP_START) begin
                        n_phase = r_phase + 1'b1;
                    end else if (r_phase == PHASE_LOW) begin
                        n_phase = '0;
                        n_bit   = r_bit + 1'b1;
                    end else begin
                        n_phase = r_phase + 1'b1;
                    end
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    // Control registers, held line levels and hold timer.
    // The timer is loaded with one less than the hold value, or zero for a hold of 0 or 1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_phase     <= '0;
            r_bit       <= '0;
            r_lead      <= 1'b0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_hold      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_lead  <= n_lead;
            if (w_issue) begin
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_hold      <= (i_hold_cycles > 16'd1) ? i_hold_cycles - 16'd1 : '0;
                r_out_valid <= 1'b1;
            end else begin
                if (r_hold != '0) begin
                    r_hold <= r_hold - 1'b1;
                end
                if (i_ready) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // Command and output payload registers.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_cmd;
        end
        if (w_issue) begin
            r_out_scl  <= n_scl;
            r_out_sda  <= n_sda;
            r_out_smp  <= w_smp;
            r_out_rx   <= w_rx;
            r_out_ack  <= w_ack;
            r_out_last <= w_fin;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_scl_level = r_out_scl;
    assign o_sda_level = r_out_sda;
    assign o_is_sample = r_out_smp;
    assign o_rx_byte   = r_out_rx;
    assign o_ack_in    = r_out_ack;
    assign o_last      = r_out_last;

    // No step leaves before its predecessor's hold time has run out.
    a_hold_respected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> (r_hold == '0))
        else $error("step issued while hold timer running");

    // The final step of a command returns the sequencer to idle.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_fin) |=> (r_state == SEQ_IDLE))
        else $error("sequencer still running after final step");

    // A sample point always sees SCL released.
    a_sample_scl_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_smp) |-> r_out_scl)
        else $error("sample step with SCL low");

    // Only the start sequence reaches its fourth phase.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == SEQ_RUN) && (r_phase == PHASE_START_END)) |-> (r_cmd.op == OP_START))
        else $error("phase out of range for command");

endmodule

@@ hw/rtl/i2c_master_bit_sequencer_unit.sv @@
// I2C master bit sequencer. Each command word (start or repeated start, stop, write byte,
// read byte, send ack, receive ack) expands into a run of 3 to 25 line steps on the
// output stream, each giving the SCL and SDA levels (1 released) with tlast on the final
// step; read steps report the sampled byte or acknowledge on that final step. Successive
// steps are paced by the hold timer in the sequencer, which is loaded from step_hold_cycles;
// with a hold of 0 or 1 one step leaves per cycle while the output stream is not stalled,
// and the sequencer passes through its idle state between commands. Opcodes 6 and 7 are
// accepted and produce no steps. A two-entry command queue lets new commands be taken
// while the sequencer is busy.
module i2c_master_bit_sequencer_unit
    import i2cms_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] tx_byte, [8] ack_out, [16:9] bus_levels
    input  logic [2:0]  s_axis_tuser,   // [2:0] opcode
    // Step stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] scl_level, [1] sda_level, [9:2] rx_byte,
                                        // [10] ack_in
    output logic [0:0]  m_axis_tuser,   // [0] is_sample
    output logic        m_axis_tlast,
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_hold_cycles;
    logic        w_front_valid;
    logic        w_front_ready;
    t_cmd        w_front_cmd;
    logic        w_q_valid;
    logic        w_q_ready;
    t_cmd        w_q_cmd;
    logic        w_scl, w_sda, w_smp, w_ack;
    logic [7:0]  w_rx;

    // Register file: step_hold_cycles at byte address 0.
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_cycles <= HOLD_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_hold_cycles <= pwdata[15:0];
        end
    end
    assign prdata = paddr[2] ? 32'h0 : {16'h0, r_hold_cycles};

    i2cms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_opcode     (s_axis_tuser),
        .i_tx_byte    (s_axis_tdata[7:0]),
        .i_ack_out    (s_axis_tdata[8]),
        .i_bus_levels (s_axis_tdata[16:9]),
        .o_cmd_valid  (w_front_valid),
        .i_cmd_ready  (w_front_ready),
        .o_cmd        (w_front_cmd)
    );

    i2cms_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_cmd   (w_front_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_cmd    (w_q_cmd)
    );

    i2cms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hold_cycles (r_hold_cycles),
        .i_cmd_valid   (w_q_valid),
        .o_cmd_ready   (w_q_ready),
        .i_cmd         (w_q_cmd),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_scl_level   (w_scl),
        .o_sda_level   (w_sda),
        .o_is_sample   (w_smp),
        .o_rx_byte     (w_rx),
        .o_ack_in      (w_ack),
        .o_last        (m_axis_tlast)
    );

    // Pack the step fields onto the output stream.
    assign m_axis_tdata = {5'b0, w_ack, w_rx, w_sda, w_scl};
    assign m_axis_tuser = w_smp;

endmodule
